// ===== src/rsmd_pkg.sv =====
// Package for the rounded saturating multiply-divide block.
// Holds the kind codes, the kind decode table and the pipeline control struct.
// No dependencies.
package rsmd_pkg;

	localparam int OP_W      = 16;
	localparam int KIND_W    = 3;
	localparam int DIV_STEPS = OP_W;

	localparam logic [KIND_W-1:0] KIND_UUU_U = 3'd0;
	localparam logic [KIND_W-1:0] KIND_SUS_S = 3'd1;
	localparam logic [KIND_W-1:0] KIND_USU_S = 3'd2;
	localparam logic [KIND_W-1:0] KIND_SUS_U = 3'd3;
	localparam logic [KIND_W-1:0] KIND_SUU_U = 3'd4;
	localparam logic [KIND_W-1:0] KIND_SSU_S = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SSS_S = 3'd6;

	localparam logic [OP_W-1:0] S_MAX = 16'h7FFF;
	localparam logic [OP_W-1:0] S_MIN = 16'h8000;
	localparam logic [OP_W-1:0] U_MAX = 16'hFFFF;

	typedef struct packed {
		logic ok;
		logic a_sgn;
		logic b_sgn;
		logic d_sgn;
		logic r_sgn;
	} kind_dec_t;

	typedef struct packed {
		logic ok;
		logic r_sgn;
		logic prod_neg;
		logic neg;
		logic dzero;
		logic ovf;
	} ctrl_t;

	function automatic kind_dec_t decode_kind(logic [KIND_W-1:0] k);
		kind_dec_t d;
		d = '0;
		case (k)
			KIND_UUU_U: d = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
			KIND_SUS_S: d = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
			KIND_USU_S: d = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
			KIND_SUS_U: d = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};
			KIND_SUU_U: d = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
			KIND_SSU_S: d = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
			KIND_SSS_S: d = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
			default:    d = '0;
		endcase
		return d;
	endfunction

endpackage

// ===== src/rounded_saturating_mul_div_16.sv =====
// Rounded saturating 16-bit multiply-divide, (a*b)/d, pipelined.
// Pipeline, in order: decode, multiply, divider entry, 16 restoring divide steps
// of one bit each, and round/saturate.
// Throughput: one request per cycle; the whole pipeline holds while the result waits.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// Depends on rsmd_pkg.
module rounded_saturating_mul_div_16 (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [15:0] first_operand, [31:16] second_operand, [47:32] divisor
	input  logic [47:0]                    s_axis_tdata,
	// [2:0] kind
	input  logic [rsmd_pkg::KIND_W-1:0]    s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [15:0] quotient
	output logic [rsmd_pkg::OP_W-1:0]      m_axis_tdata
);
	import rsmd_pkg::*;

	logic adv;

	// stage 1: decode and magnitudes
	logic              vld_s1;
	kind_dec_t         dec_s1;
	logic [OP_W-1:0]   ma_s1, mb_s1, md_s1;
	logic              na_s1, nb_s1, nd_s1;

	// stage 2: product
	logic              vld_s2;
	ctrl_t             ctrl_s2;
	logic [2*OP_W-1:0] mp_s2;
	logic [OP_W-1:0]   md_s2;

	// divider stages
	logic              dv_vld_s  [0:DIV_STEPS];
	ctrl_t             dv_ctrl_s [0:DIV_STEPS];
	logic [OP_W-1:0]   dv_rem_s  [0:DIV_STEPS];
	logic [OP_W-1:0]   dv_num_s  [0:DIV_STEPS];
	logic [OP_W-1:0]   dv_quo_s  [0:DIV_STEPS];
	logic [OP_W-1:0]   dv_md_s   [0:DIV_STEPS];

	// output
	logic              out_vld_q;
	logic [OP_W-1:0]   quotient_q;

	assign adv           = !out_vld_q || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = quotient_q;

	// ---- stage 1
	logic [OP_W-1:0] in_a, in_b, in_d;
	kind_dec_t       in_dec;
	logic            in_na, in_nb, in_nd;

	always_comb begin
		in_a   = s_axis_tdata[OP_W-1:0];
		in_b   = s_axis_tdata[2*OP_W-1:OP_W];
		in_d   = s_axis_tdata[3*OP_W-1:2*OP_W];
		in_dec = decode_kind(s_axis_tuser);
		in_na  = in_dec.a_sgn && in_a[OP_W-1];
		in_nb  = in_dec.b_sgn && in_b[OP_W-1];
		in_nd  = in_dec.d_sgn && in_d[OP_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= in_dec;
			na_s1  <= in_na;
			nb_s1  <= in_nb;
			nd_s1  <= in_nd;
			ma_s1  <= in_na ? (~in_a + 1'b1) : in_a;
			mb_s1  <= in_nb ? (~in_b + 1'b1) : in_b;
			md_s1  <= in_nd ? (~in_d + 1'b1) : in_d;
		end
	end

	// ---- stage 2
	logic pneg_s1;
	assign pneg_s1 = (ma_s1 != '0) && (mb_s1 != '0) && (na_s1 ^ nb_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mp_s2            <= ma_s1 * mb_s1;
			md_s2            <= md_s1;
			ctrl_s2.ok       <= dec_s1.ok;
			ctrl_s2.r_sgn    <= dec_s1.r_sgn;
			ctrl_s2.prod_neg <= pneg_s1;
			ctrl_s2.neg      <= pneg_s1 ^ nd_s1;
			ctrl_s2.dzero    <= (md_s1 == '0);
			ctrl_s2.ovf      <= 1'b0;
		end
	end

	// ---- divider entry; quotient above 16 bits means saturation
	ctrl_t dv_entry_ctrl;

	always_comb begin
		dv_entry_ctrl     = ctrl_s2;
		dv_entry_ctrl.ovf = (mp_s2[2*OP_W-1:OP_W] >= md_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (adv) begin
			dv_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_rem_s[0]  <= mp_s2[2*OP_W-1:OP_W];
			dv_num_s[0]  <= mp_s2[OP_W-1:0];
			dv_quo_s[0]  <= '0;
			dv_md_s[0]   <= md_s2;
			dv_ctrl_s[0] <= dv_entry_ctrl;
		end
	end

	// ---- restoring divide, one quotient bit per stage
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
		logic [OP_W:0] trial;
		logic [OP_W:0] diff;
		logic          ge;

		always_comb begin
			trial = {dv_rem_s[i], dv_num_s[i][OP_W-1]};
			diff  = trial - {1'b0, dv_md_s[i]};
			ge    = (trial >= {1'b0, dv_md_s[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[i+1] <= dv_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[i+1]  <= ge ? diff[OP_W-1:0] : trial[OP_W-1:0];
				dv_num_s[i+1]  <= {dv_num_s[i][OP_W-2:0], 1'b0};
				dv_quo_s[i+1]  <= {dv_quo_s[i][OP_W-2:0], ge};
				dv_md_s[i+1]   <= dv_md_s[i];
				dv_ctrl_s[i+1] <= dv_ctrl_s[i];
			end
		end
	end

	// ---- round half away from zero and saturate
	ctrl_t           fc;
	logic            rnd;
	logic [OP_W:0]   qm;
	logic [OP_W:0]   mag;
	logic [OP_W-1:0] res;

	always_comb begin
		fc  = dv_ctrl_s[DIV_STEPS];
		rnd = ({dv_rem_s[DIV_STEPS], 1'b0} >= {1'b0, dv_md_s[DIV_STEPS]});
		qm  = {1'b0, dv_quo_s[DIV_STEPS]} + {{OP_W{1'b0}}, rnd};
		mag = (fc.ovf || qm > {1'b0, S_MIN}) ? {1'b0, S_MIN} : qm;
		res = '0;
		if (!fc.ok) begin
			res = '0;
		end else if (fc.dzero) begin
			if (fc.prod_neg) begin
				res = fc.r_sgn ? S_MIN : '0;
			end else begin
				res = fc.r_sgn ? S_MAX : U_MAX;
			end
		end else if (!fc.ovf && qm == '0) begin
			res = '0;
		end else if (fc.neg) begin
			res = fc.r_sgn ? (~mag[OP_W-1:0] + 1'b1) : '0;
		end else if (fc.r_sgn) begin
			res = (fc.ovf || qm > {1'b0, S_MAX}) ? S_MAX : qm[OP_W-1:0];
		end else begin
			res = (fc.ovf || qm[OP_W]) ? U_MAX : qm[OP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= dv_vld_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quotient_q <= res;
		end
	end

endmodule

// ===== bench/rsmd_quotient_checker.sv =====
// Checker for the rounded saturating multiply-divide: watches both stream channels,
// computes each expected quotient on request accept and compares on result accept.
// Depends on rsmd_pkg.
module rsmd_quotient_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic [47:0]                   req_data,
	input  logic [rsmd_pkg::KIND_W-1:0]   req_kind,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [rsmd_pkg::OP_W-1:0]     res_data,
	output int                            mismatches,
	output int                            outstanding
);
	import rsmd_pkg::*;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OP_W-1:0]   a;
		logic [OP_W-1:0]   b;
		logic [OP_W-1:0]   d;
		logic [OP_W-1:0]   quotient;
	} pending_quotient_t;

	pending_quotient_t quotient_q[$];

	function automatic logic [OP_W-1:0] rounded_quotient(logic [KIND_W-1:0] k,
			logic [OP_W-1:0] a, logic [OP_W-1:0] b, logic [OP_W-1:0] d);
		logic a_s, b_s, d_s, r_s;
		logic na, nb, nd, prod_neg, neg;
		logic [33:0] ma, mb, md, prod, quo, rem, lim;
		case (k)
			KIND_UUU_U: {a_s, b_s, d_s, r_s} = 4'b0000;
			KIND_SUS_S: {a_s, b_s, d_s, r_s} = 4'b1011;
			KIND_USU_S: {a_s, b_s, d_s, r_s} = 4'b0101;
			KIND_SUS_U: {a_s, b_s, d_s, r_s} = 4'b1010;
			KIND_SUU_U: {a_s, b_s, d_s, r_s} = 4'b1000;
			KIND_SSU_S: {a_s, b_s, d_s, r_s} = 4'b1101;
			KIND_SSS_S: {a_s, b_s, d_s, r_s} = 4'b1111;
			default: return '0;
		endcase
		na = a_s & a[OP_W-1];
		nb = b_s & b[OP_W-1];
		nd = d_s & d[OP_W-1];
		ma = na ? 34'h10000 - {18'd0, a} : {18'd0, a};
		mb = nb ? 34'h10000 - {18'd0, b} : {18'd0, b};
		md = nd ? 34'h10000 - {18'd0, d} : {18'd0, d};
		prod = ma * mb;
		prod_neg = (prod != 0) && (na != nb);
		if (md == 0) begin
			if (prod_neg)
				return r_s ? S_MIN : '0;
			return r_s ? S_MAX : U_MAX;
		end
		neg = prod_neg != nd;
		quo = prod / md;
		rem = prod % md;
		if (rem * 2 >= md)
			quo = quo + 1;
		if (quo == 0)
			return '0;
		if (neg) begin
			if (!r_s)
				return '0;
			if (quo > 34'd32768)
				quo = 34'd32768;
			return -quo[OP_W-1:0];
		end
		lim = r_s ? {18'd0, S_MAX} : {18'd0, U_MAX};
		return (quo > lim) ? lim[OP_W-1:0] : quo[OP_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pending_quotient_t want;
		if (!arst_n) begin
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (req_valid && req_ready) begin
				want.kind = req_kind;
				want.a = req_data[15:0];
				want.b = req_data[31:16];
				want.d = req_data[47:32];
				want.quotient = rounded_quotient(req_kind, want.a, want.b, want.d);
				quotient_q.push_back(want);
			end
			if (res_valid && res_ready) begin
				if (quotient_q.size() == 0) begin
					$display("%0t: result with no request pending: expected none, actual %h",
						$time, res_data);
					mismatches <= mismatches + 1;
				end else begin
					want = quotient_q.pop_front();
					if (res_data !== want.quotient) begin
						$display("%0t: quotient mismatch kind %0d a %h b %h d %h: expected %h, actual %h",
							$time, want.kind, want.a, want.b, want.d, want.quotient, res_data);
						mismatches <= mismatches + 1;
					end
				end
			end
			outstanding <= quotient_q.size();
		end
	end

endmodule

// ===== bench/tb_rounded_saturating_mul_div_16.sv =====
// Testbench top for rounded_saturating_mul_div_16: drives directed and random requests
// under several idle/stall mixes and reports the verdict from rsmd_quotient_checker.
// Depends on rsmd_pkg, rounded_saturating_mul_div_16 and rsmd_quotient_checker.
module tb_rounded_saturating_mul_div_16;
	import rsmd_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
	localparam int HOLD_CYCLES      = 200;
	localparam int STALL_LIMIT      = 5000;
	localparam int DRAIN_CYCLES     = 40;
	localparam int RANDOM_PER_PHASE = 220;

	logic              clk           = 1'b0;
	logic              arst_n        = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata  = '0;
	logic [KIND_W-1:0] s_axis_tuser  = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [OP_W-1:0]   m_axis_tdata;

	int  sender_idle_pct    = 0;
	int  receiver_stall_pct = 0;
	bit  hold_request       = 1'b0;
	int  held_cycles        = 0;
	int  quiet_cycles       = 0;
	int  mismatches;
	int  outstanding;

	always #6 clk = ~clk;

	rounded_saturating_mul_div_16 DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	rsmd_quotient_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (s_axis_tvalid),
		.req_ready   (s_axis_tready),
		.req_data    (s_axis_tdata),
		.req_kind    (s_axis_tuser),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_data    (m_axis_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (hold_request && held_cycles < HOLD_CYCLES) begin
			m_axis_tready <= 1'b0;
			held_cycles <= held_cycles + 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_request(input logic [KIND_W-1:0] k, input logic [OP_W-1:0] a,
			input logic [OP_W-1:0] b, input logic [OP_W-1:0] d);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= k;
		s_axis_tdata  <= {d, b, a};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	function automatic logic [OP_W-1:0] random_operand();
		case ($urandom_range(9))
			0: return '0;
			1: return 16'd1;
			2: return S_MAX;
			3: return S_MIN;
			4: return U_MAX;
			5: return 16'($urandom_range(15));
			6: return 16'(-$urandom_range(16, 1));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [OP_W-1:0] random_divisor();
		case ($urandom_range(11))
			0: return '0;
			1: return 16'd1;
			2: return 16'd2;
			3: return U_MAX;
			4: return 16'hFFFE;
			5: return S_MIN;
			6: return 16'($urandom_range(255));
			7: return 16'(-$urandom_range(256, 1));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random(input int count);
		logic [KIND_W-1:0] k;
		for (int i = 0; i < count; i++) begin
			k = ($urandom_range(15) == 0) ? KIND_UNUSED
				: KIND_W'($urandom_range(KIND_SSS_S, KIND_UUU_U));
			send_request(k, random_operand(), random_operand(), random_divisor());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: one per kind, zero divisor, saturation, ties, sign corners
		send_request(KIND_UUU_U, 16'd3, 16'd1, 16'd2);
		send_request(KIND_SUS_S, 16'hFFFD, 16'd1, 16'd2);
		send_request(KIND_USU_S, 16'd7, 16'hFFFF, 16'd3);
		send_request(KIND_SUS_U, 16'hFFFF, 16'd9, 16'hFFFD);
		send_request(KIND_SUU_U, 16'hFFFF, 16'd5, 16'd1);
		send_request(KIND_SSU_S, 16'hFFFF, 16'hFFFF, 16'd2);
		send_request(KIND_SSS_S, 16'hFFFD, 16'd1, 16'd2);
		send_request(KIND_UNUSED, U_MAX, U_MAX, U_MAX);
		send_request(KIND_UNUSED, '0, '0, '0);
		send_request(KIND_SSS_S, 16'd5, 16'd7, '0);
		send_request(KIND_SSS_S, 16'hFFFB, 16'd7, '0);
		send_request(KIND_SUU_U, 16'hFFFB, 16'd7, '0);
		send_request(KIND_UUU_U, 16'd5, 16'd7, '0);
		send_request(KIND_UUU_U, '0, U_MAX, '0);
		send_request(KIND_UUU_U, U_MAX, U_MAX, 16'd1);
		send_request(KIND_SSS_S, S_MIN, S_MAX, 16'd1);
		send_request(KIND_SSS_S, S_MIN, S_MIN, 16'd1);
		send_request(KIND_SSS_S, S_MIN, U_MAX, U_MAX);
		send_request(KIND_SSS_S, '0, 16'd5, U_MAX);
		send_request(KIND_SUS_S, S_MIN, U_MAX, S_MIN);
		send_request(KIND_USU_S, U_MAX, S_MIN, 16'd1);
		send_request(KIND_UUU_U, U_MAX, U_MAX, U_MAX);
		send_request(KIND_SSU_S, 16'd5, 16'd5, 16'd10);
		send_request(KIND_SSU_S, 16'hFFFB, 16'd5, 16'd10);

		// no idling, with a long receiver hold-off while requests keep coming
		hold_request <= 1'b1;
		send_random(RANDOM_PER_PHASE);
		wait_drained();

		sender_idle_pct <= 48;
		send_random(RANDOM_PER_PHASE);
		wait_drained();

		sender_idle_pct <= 0;
		receiver_stall_pct <= 48;
		send_random(RANDOM_PER_PHASE);
		wait_drained();

		sender_idle_pct <= 13;
		receiver_stall_pct <= 13;
		send_random(RANDOM_PER_PHASE);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/rsmd_pkg.sv
src/rounded_saturating_mul_div_16.sv
bench/rsmd_quotient_checker.sv
bench/tb_rounded_saturating_mul_div_16.sv
